FILE: src/neighbor_pair_cutoff_filter_top_assert.svh
// Assertion macros for the neighbor pair cutoff filter.
// Expects signals clk and rst in the scope of each use.
`ifndef NEIGHBOR_PAIR_CUTOFF_FILTER_TOP_ASSERT_SVH
`define NEIGHBOR_PAIR_CUTOFF_FILTER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define NPCF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npcf: check failed");

// Check that cons holds in the cycle after ante.
`define NPCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npcf: check failed");

`endif

FILE: src/npcf_pkg.sv
// Shared types and constants for the neighbor pair cutoff filter.
// No dependencies; used by npcf_sqrt_pipe and the top level.
package npcf_pkg;

  localparam int IDX_W   = 16;
  localparam int COORD_W = 32;
  localparam int DIST_W  = 31;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = SQ_W / 2;

  // Square root pipeline: two digit steps per stage, one root bit per step.
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

  localparam logic [DIST_W-1:0] CUTOFF_RESET = 31'd340787;

  typedef struct packed {
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          second_index;
    logic [1:0]                dummy_mask;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
    logic signed [COORD_W-1:0] shift_z;
  } npcf_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]          kept_first_index;
    logic [IDX_W-1:0]          kept_second_index;
    logic [DIST_W-1:0]         pair_distance;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic signed [COORD_W-1:0] delta_z;
  } npcf_res_t;

  // Fields that ride alongside the squared length through the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]          kept_first_index;
    logic [IDX_W-1:0]          kept_second_index;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic signed [COORD_W-1:0] delta_z;
  } npcf_carry_t;

endpackage

FILE: src/npcf_sqrt_pipe.sv
// Pipelined digit-by-digit square root with round to nearest.
// Depends on npcf_pkg; carries a side payload alongside the radicand.
module npcf_sqrt_pipe
  import npcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_radicand,
  input  npcf_carry_t       in_carry,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_root,
  output npcf_carry_t       out_carry
);

  localparam int REM_W = ROOT_W + 4;

  typedef struct packed {
    logic [SQ_W-1:0]   rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sq_state_t;

  // One restoring step: bring down two radicand bits, try (root << 2) | 1.
  function automatic sq_state_t sqrt_step(input sq_state_t s);
    sq_state_t        n;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    shifted = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
    trial   = {2'b00, s.root, 2'b01};
    n.rad   = {s.rad[SQ_W-3:0], 2'b00};
    if (shifted >= trial) begin
      n.rem  = shifted - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = shifted;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  logic        stg_valid [SQRT_STAGES];
  sq_state_t   stg       [SQRT_STAGES];
  npcf_carry_t stg_carry [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic        prev_valid;
    sq_state_t   prev;
    npcf_carry_t prev_carry;
    sq_state_t   nxt;

    if (g == 0) begin : g_head
      assign prev_valid = in_valid;
      assign prev       = '{rad: in_radicand, root: '0, rem: '0};
      assign prev_carry = in_carry;
    end else begin : g_tail
      assign prev_valid = stg_valid[g-1];
      assign prev       = stg[g-1];
      assign prev_carry = stg_carry[g-1];
    end

    always_comb begin
      nxt = prev;
      for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
        nxt = sqrt_step(nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[g] <= 1'b0;
      end else begin
        stg_valid[g] <= prev_valid;
      end
      stg[g]       <= nxt;
      stg_carry[g] <= prev_carry;
    end
  end

  // Round: remainder above the root means the true root is past root + 1/2.
  logic [ROOT_W-1:0] rounded;

  always_comb begin
    if (stg[SQRT_STAGES-1].rem > REM_W'(stg[SQRT_STAGES-1].root)) begin
      rounded = stg[SQRT_STAGES-1].root + ROOT_W'(1);
    end else begin
      rounded = stg[SQRT_STAGES-1].root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= stg_valid[SQRT_STAGES-1];
    end
    out_root  <= rounded[DIST_W-1:0];
    out_carry <= stg_carry[SQRT_STAGES-1];
  end

endmodule

FILE: src/neighbor_pair_cutoff_filter_top.sv
// Neighbor pair cutoff filter, top level.
// Depends on npcf_pkg, npcf_sqrt_pipe and neighbor_pair_cutoff_filter_top_assert.svh.
//
// Takes one candidate atom pair request per clock (start high while busy is low) and
// forms diff = first - second + shift per axis, saturated to signed Q15.16. A request
// with either dummy_mask bit set, or whose squared length exceeds the squared cutoff,
// is dropped silently. A kept pair's one-cycle done strobe is accepted at the 22nd
// rising edge after its request edge, carrying both indices (masked to ATOM_INDEX_BITS),
// the rounded distance and the diff vector; results leave in request order and the
// receiver cannot hold them off. The datapath is fully pipelined: 5 front stages
// (diff, magnitude, square, sum, cutoff test), 16 square root stages of two digit
// steps each, and one rounding stage, so throughput is one request per cycle and
// busy is high only while in reset. cutoff_distance is written through cfg_we and
// cfg_wdata; write it only while no request is in flight, since its square is
// registered one cycle after the write and used at the cutoff test stage.
`include "neighbor_pair_cutoff_filter_top_assert.svh"

module neighbor_pair_cutoff_filter_top
  import npcf_pkg::*;
#(
  parameter int ATOM_INDEX_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  npcf_req_t         request,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_wdata,
  output logic              done,
  output npcf_res_t         result
);

  localparam logic [IDX_W-1:0] IDX_MASK = (ATOM_INDEX_BITS >= IDX_W) ? '1 :
      IDX_W'((32'd1 << ATOM_INDEX_BITS) - 32'd1);
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + 1;

  // first - second + shift, exact in 34 bits, then clamp to signed 32.
  function automatic logic signed [COORD_W-1:0] sat_diff(
    input logic signed [COORD_W-1:0] p,
    input logic signed [COORD_W-1:0] q,
    input logic signed [COORD_W-1:0] s
  );
    logic signed [COORD_W+1:0] full;
    full = (COORD_W+2)'(p) - (COORD_W+2)'(q) + (COORD_W+2)'(s);
    if (full > (COORD_W+2)'(signed'(34'sh0_7FFF_FFFF))) begin
      sat_diff = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (full < -(COORD_W+2)'(signed'(34'sh0_8000_0000))) begin
      sat_diff = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_diff = full[COORD_W-1:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] magnitude(input logic signed [COORD_W-1:0] d);
    if (d[COORD_W-1]) begin
      magnitude = ~d + COORD_W'(1);
    end else begin
      magnitude = d;
    end
  endfunction

  logic accept;
  assign accept = start && !busy;

  // Hold off requests only while in reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Cutoff register and its square.
  logic [DIST_W-1:0]   cutoff;
  logic [2*DIST_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
    end else if (cfg_we) begin
      cutoff <= cfg_wdata;
    end
    lim <= (2*DIST_W)'(cutoff) * (2*DIST_W)'(cutoff);
  end

  // Stage 1: saturated diff; drop padding pairs here.
  logic        v1;
  npcf_carry_t c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept && (request.dummy_mask == 2'b00);
    end
    c1.kept_first_index  <= request.first_index & IDX_MASK;
    c1.kept_second_index <= request.second_index & IDX_MASK;
    c1.delta_x <= sat_diff(request.first_x, request.second_x, request.shift_x);
    c1.delta_y <= sat_diff(request.first_y, request.second_y, request.shift_y);
    c1.delta_z <= sat_diff(request.first_z, request.second_z, request.shift_z);
  end

  // Stage 2: magnitudes.
  logic               v2;
  npcf_carry_t        c2;
  logic [COORD_W-1:0] mag2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    c2      <= c1;
    mag2[0] <= magnitude(c1.delta_x);
    mag2[1] <= magnitude(c1.delta_y);
    mag2[2] <= magnitude(c1.delta_z);
  end

  // Stage 3: one 32x32 square per axis.
  logic            v3;
  npcf_carry_t     c3;
  logic [SQ_W-1:0] sq3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    c3 <= c2;
    for (int a = 0; a < 3; a++) begin
      sq3[a] <= SQ_W'(mag2[a]) * SQ_W'(mag2[a]);
    end
  end

  // Stage 4: squared length; at most 3 * 2^62, so 64 bits never wrap.
  logic            v4;
  npcf_carry_t     c4;
  logic [SQ_W-1:0] sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    c4   <= c3;
    sum4 <= sq3[0] + sq3[1] + sq3[2];
  end

  // Stage 5: cutoff test, boundary kept.
  logic            v5;
  npcf_carry_t     c5;
  logic [SQ_W-1:0] sum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4 && (sum4 <= SQ_W'(lim));
    end
    c5   <= c4;
    sum5 <= sum4;
  end

  // Distance and output register.
  logic [DIST_W-1:0] pair_dist;
  npcf_carry_t       cq;

  npcf_sqrt_pipe u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v5),
    .in_radicand (sum5),
    .in_carry    (c5),
    .out_valid   (done),
    .out_root    (pair_dist),
    .out_carry   (cq)
  );

  assign result = '{
    kept_first_index:  cq.kept_first_index,
    kept_second_index: cq.kept_second_index,
    pair_distance:     pair_dist,
    delta_x:           cq.delta_x,
    delta_y:           cq.delta_y,
    delta_z:           cq.delta_z
  };

  `NPCF_ASSERT_IMPL(a_done_from_live_request, done,
      $past(start && !busy && request.dummy_mask == 2'b00, LATENCY))
  `NPCF_ASSERT_IMPL(a_indices_follow, done,
      result.kept_first_index == ($past(request.first_index, LATENCY) & IDX_MASK) &&
      result.kept_second_index == ($past(request.second_index, LATENCY) & IDX_MASK))
  `NPCF_ASSERT_IMPL(a_zero_distance, done,
      (result.pair_distance == '0) ==
      (result.delta_x == '0 && result.delta_y == '0 && result.delta_z == '0))
  `NPCF_ASSERT_NEXT(a_never_stalls, start && !busy, !busy)

endmodule

FILE: verif/testbench.sv
// Testbench for neighbor_pair_cutoff_filter_top: stimulus, an in-bench cutoff filter predictor
// and a result checker. Depends only on npcf_pkg and the RTL of the block.
module testbench;
  import npcf_pkg::*;

  localparam int ATOM_INDEX_BITS = 16;
  // Depth of the block from request to kept result; drain adds margin for dropped pairs in flight.
  localparam int PIPE_LATENCY = 22;
  localparam int LIMIT_CYCLES = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;
  // Spread of well-formed coordinates; keeps first = second + diff - shift in range.
  localparam longint SPREAD = 536870912;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0] vec_t;   // {x, y, z}

  localparam coord_t CZERO = 32'sd0;
  localparam coord_t CONE  = 32'sd65536;   // 1.0 in Q15.16
  localparam coord_t CMAX  = 32'sh7fffffff;
  localparam coord_t CMIN  = 32'sh80000000;
  localparam logic [DIST_W-1:0] CUTOFF_MAX = 31'h7fffffff;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  npcf_req_t         request = '0;
  logic              cfg_we = 1'b0;
  logic [DIST_W-1:0] cfg_wdata = '0;
  logic              done;
  npcf_res_t         result;

  // Cutoff the block holds now; changes only while the pipeline is empty.
  logic [DIST_W-1:0] cutoff_now = CUTOFF_RESET;
  npcf_res_t         kept_pairs_q[$];
  int                sender_idle_pct = 0;
  int                pairs_sent = 0;
  int                pairs_checked = 0;
  int                cutoffs_written = 0;
  int                fault_count = 0;
  int                cycle_count = 0;

  neighbor_pair_cutoff_filter_top #(
    .ATOM_INDEX_BITS(ATOM_INDEX_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: diff = first - second + shift per axis, saturated to 32 bits;
  // drop on any padding bit or when |diff|^2 exceeds cutoff^2; the distance is
  // the square root of |diff|^2 rounded to nearest.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rounded_root(input logic [63:0] sq);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = sq;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > sq) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // Round up when the remainder passes the root; ties are impossible.
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic bit filter_pair(input npcf_req_t p, input logic [DIST_W-1:0] cut,
                                     output npcf_res_t r);
    coord_t      fa[3];
    coord_t      sa[3];
    coord_t      ha[3];
    longint      diff[3];
    logic [63:0] mag;
    logic [63:0] len_sq;
    logic [63:0] cut_sq;
    logic [63:0] root;
    logic [15:0] idx_mask;
    fa[0] = p.first_x;  fa[1] = p.first_y;  fa[2] = p.first_z;
    sa[0] = p.second_x; sa[1] = p.second_y; sa[2] = p.second_z;
    ha[0] = p.shift_x;  ha[1] = p.shift_y;  ha[2] = p.shift_z;
    len_sq = '0;
    for (int a = 0; a < 3; a++) begin
      diff[a] = longint'(fa[a]) - longint'(sa[a]) + longint'(ha[a]);
      if (diff[a] > SAT_HI) diff[a] = SAT_HI;
      if (diff[a] < SAT_LO) diff[a] = SAT_LO;
      mag = (diff[a] < 0) ? 64'(-diff[a]) : 64'(diff[a]);
      len_sq = len_sq + mag * mag;
    end
    cut_sq   = 64'(cut) * 64'(cut);
    root     = rounded_root(len_sq);
    idx_mask = 16'((32'h1 << ATOM_INDEX_BITS) - 1);
    r.kept_first_index  = p.first_index & idx_mask;
    r.kept_second_index = p.second_index & idx_mask;
    r.pair_distance     = root[DIST_W-1:0];
    r.delta_x           = diff[0][31:0];
    r.delta_y           = diff[1][31:0];
    r.delta_z           = diff[2][31:0];
    return (p.dummy_mask == 2'b00) && (len_sq <= cut_sq);
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic npcf_req_t build_pair(input logic [15:0] fi, input logic [15:0] si,
                                           input logic [1:0] mask, input vec_t f,
                                           input vec_t s, input vec_t h);
    npcf_req_t p;
    p.first_index  = fi;
    p.second_index = si;
    p.dummy_mask   = mask;
    p.first_x  = f[2]; p.first_y  = f[1]; p.first_z  = f[0];
    p.second_x = s[2]; p.second_y = s[1]; p.second_z = s[0];
    p.shift_x  = h[2]; p.shift_y  = h[1]; p.shift_z  = h[0];
    return p;
  endfunction

  // Uniform value in [-lim, lim].
  function automatic coord_t span(input longint lim);
    return coord_t'(longint'($urandom_range(32'(2 * lim), 0)) - lim);
  endfunction

  function automatic logic [1:0] random_mask(input int pct);
    return ($urandom_range(0, 99) < pct) ? 2'($urandom_range(1, 3)) : 2'b00;
  endfunction

  // Pair whose diff lies in the cube around the cutoff sphere, shift or no shift.
  function automatic npcf_req_t near_pair(input logic [DIST_W-1:0] cut);
    vec_t   f;
    vec_t   s;
    vec_t   h;
    coord_t sc;
    coord_t hc;
    longint reach;
    reach = longint'(cut) + 1;
    if (reach > SPREAD) reach = SPREAD;
    for (int a = 0; a < 3; a++) begin
      sc   = span(SPREAD);
      hc   = ($urandom_range(0, 1) == 0) ? CZERO : span(SPREAD);
      s[a] = sc;
      h[a] = hc;
      f[a] = 32'(longint'(sc) + longint'(span(reach)) - longint'(hc));
    end
    return build_pair(16'($urandom), 16'($urandom), random_mask(15), f, s, h);
  endfunction

  // Diff of exactly the cutoff, or one past it, on one axis; other axes zero.
  function automatic npcf_req_t boundary_pair(input logic [DIST_W-1:0] cut);
    vec_t   f;
    vec_t   s;
    longint d;
    int     a;
    coord_t hi;
    coord_t lo;
    a = $urandom_range(0, 2);
    d = longint'(cut) + $urandom_range(0, 1);
    if (d > SAT_HI) d = cut;
    hi = coord_t'(d - (d >>> 1));
    lo = coord_t'(-(d >>> 1));
    for (int i = 0; i < 3; i++) begin
      f[i] = $urandom;
      s[i] = f[i];
    end
    if ($urandom_range(0, 1) == 0) begin
      f[a] = hi; s[a] = lo;
    end else begin
      f[a] = lo; s[a] = hi;
    end
    return build_pair(16'($urandom), 16'($urandom), random_mask(10), f, s, '0);
  endfunction

  function automatic coord_t corner_value();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return CZERO;
      3: return -32'sd1;
      4: return CONE;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] corner_index();
    case ($urandom_range(0, 2))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Coordinates at the ends of the range, to exercise saturation.
  function automatic npcf_req_t extreme_pair();
    vec_t f;
    vec_t s;
    vec_t h;
    for (int a = 0; a < 3; a++) begin
      f[a] = corner_value();
      s[a] = corner_value();
      h[a] = corner_value();
    end
    return build_pair(corner_index(), corner_index(), random_mask(25), f, s, h);
  endfunction

  function automatic npcf_req_t noise_pair();
    vec_t f;
    vec_t s;
    vec_t h;
    for (int a = 0; a < 3; a++) begin
      f[a] = $urandom;
      s[a] = $urandom;
      h[a] = $urandom;
    end
    return build_pair(16'($urandom), 16'($urandom), 2'($urandom), f, s, h);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Present one request, hold it until accepted, then record its prediction.
  // Leave start high unless the sender idles, so back-to-back requests stream.
  task automatic send_pair(input npcf_req_t p);
    npcf_res_t expected;
    int        gap;
    start   <= 1'b1;
    request <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (filter_pair(p, cutoff_now, expected))
      kept_pairs_q.insert(kept_pairs_q.size(), expected);
    pairs_sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start, wait for every expected pair, then let dropped ones flush too.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (kept_pairs_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // Write the cutoff with nothing in flight; the block registers its square from the cutoff register.
  task automatic set_cutoff(input logic [DIST_W-1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cutoff_now  = value;
    cutoffs_written++;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_pairs(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      send_pair(near_pair(cutoff_now));
      else if (pick < 75) send_pair(boundary_pair(cutoff_now));
      else if (pick < 90) send_pair(noise_pair());
      else                send_pair(extreme_pair());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker: every strobed result must match the oldest kept-pair prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    npcf_res_t want;
    if (!rst && done) begin
      if (kept_pairs_q.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result: idx %h/%h dist %h delta %h %h %h",
                   result.kept_first_index, result.kept_second_index, result.pair_distance,
                   result.delta_x, result.delta_y, result.delta_z);
      end else begin
        want = kept_pairs_q.pop_front();
        pairs_checked++;
        if (result.kept_first_index !== want.kept_first_index ||
            result.kept_second_index !== want.kept_second_index ||
            result.pair_distance !== want.pair_distance ||
            result.delta_x !== want.delta_x ||
            result.delta_y !== want.delta_y ||
            result.delta_z !== want.delta_z) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("mismatch: expected idx %h/%h dist %h delta %h %h %h",
                     want.kept_first_index, want.kept_second_index, want.pair_distance,
                     want.delta_x, want.delta_y, want.delta_z);
            $display("          actual   idx %h/%h dist %h delta %h %h %h",
                     result.kept_first_index, result.kept_second_index,
                     result.pair_distance, result.delta_x, result.delta_y, result.delta_z);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Directed pairs at the reset cutoff (about 5.2), which is never written first.
  task automatic test_reset_cutoff();
    coord_t c;
    coord_t c1;
    c  = coord_t'(CUTOFF_RESET);
    c1 = c + 32'sd1;
    sender_idle_pct = 0;
    send_pair(build_pair(16'h0000, 16'h0000, 2'b00, '0, '0, '0));
    // Squared length equal to the squared cutoff is kept; one more is not.
    send_pair(build_pair(16'hffff, 16'hffff, 2'b00, {c, CZERO, CZERO}, '0, '0));
    send_pair(build_pair(16'h0001, 16'h0002, 2'b00, {CZERO, c1, CZERO}, '0, '0));
    send_pair(build_pair(16'h5555, 16'haaaa, 2'b00, '0, {CZERO, CZERO, c}, '0));
    // 3-4-5 triangle, exact root; then a root that rounds up.
    send_pair(build_pair(16'haaaa, 16'h5555, 2'b00, {3 * CONE, 4 * CONE, CZERO}, '0, '0));
    send_pair(build_pair(16'h0003, 16'h0004, 2'b00, {32'sd1, 32'sd1, 32'sd1}, '0, '0));
    // Any padding atom drops the pair.
    send_pair(build_pair(16'h0005, 16'h0006, 2'b01, '0, '0, '0));
    send_pair(build_pair(16'h0007, 16'h0008, 2'b10, '0, '0, '0));
    send_pair(build_pair(16'h0009, 16'h000a, 2'b11, '0, '0, '0));
    // Periodic shift pulls a far image into range.
    send_pair(build_pair(16'h000b, 16'h000c, 2'b00, {10 * CONE, CZERO, CZERO}, '0,
                         {-9 * CONE, CZERO, CZERO}));
    send_pair(build_pair(16'h000d, 16'h000e, 2'b00, {CMIN, CMAX, CMIN}, {CMIN, CMAX, CMIN},
                         '0));
    // Diff overflow both ways saturates and falls outside the cutoff.
    send_pair(build_pair(16'h000f, 16'h0010, 2'b00, {CMAX, CZERO, CZERO},
                         {CMIN, CZERO, CZERO}, {CMAX, CZERO, CZERO}));
    send_pair(build_pair(16'h0011, 16'h0012, 2'b00, {CZERO, CMIN, CZERO},
                         {CZERO, CMAX, CZERO}, {CZERO, CMIN, CZERO}));
  endtask

  // Zero cutoff keeps only pairs whose diff is exactly zero.
  task automatic test_zero_cutoff();
    set_cutoff('0);
    sender_idle_pct = 0;
    send_pair(build_pair(16'h0100, 16'h0200, 2'b00, {CONE, CZERO, CONE}, '0,
                         {-CONE, CZERO, -CONE}));
    send_pair(build_pair(16'h0101, 16'h0201, 2'b00, {32'sd1, CZERO, CZERO}, '0, '0));
    send_pair(build_pair(16'h0102, 16'h0202, 2'b11, '0, '0, '0));
    send_pair(build_pair(16'h0103, 16'h0203, 2'b00, {CMAX, CMIN, CMAX}, {CMAX, CMIN, CMAX},
                         '0));
    sender_idle_pct = 25;
    random_pairs(40);
  endtask

  // Largest cutoff: a single saturated positive axis sits exactly on the boundary.
  task automatic test_max_cutoff();
    set_cutoff(CUTOFF_MAX);
    sender_idle_pct = 0;
    send_pair(build_pair(16'h0300, 16'h0400, 2'b00, {CMAX, CZERO, CZERO},
                         {CMIN, CZERO, CZERO}, {CMAX, CZERO, CZERO}));
    send_pair(build_pair(16'h0301, 16'h0401, 2'b00, {CZERO, CZERO, CMIN},
                         {CZERO, CZERO, CMAX}, {CZERO, CZERO, CMIN}));
    send_pair(build_pair(16'h0302, 16'h0402, 2'b00, {CMAX, CMAX, CZERO},
                         {CMIN, CMIN, CZERO}, '0));
    send_pair(build_pair(16'h0303, 16'h0403, 2'b00, {32'sh40000000, 32'sh40000000, CZERO},
                         '0, '0));
    send_pair(build_pair(16'h0304, 16'h0404, 2'b00, {CZERO, CMIN + 32'sd1, CZERO}, '0, '0));
    sender_idle_pct = 60;
    random_pairs(40);
  endtask

  // Mixed random traffic over several cutoffs and sender idle rates.
  task automatic test_random_traffic();
    logic [DIST_W-1:0] cut_set[6];
    int                idle_set[6];
    cut_set[0] = CUTOFF_RESET;
    cut_set[1] = DIST_W'($urandom_range(16, 1 << 24));
    cut_set[2] = CUTOFF_MAX;
    cut_set[3] = DIST_W'($urandom);
    cut_set[4] = 31'd1;
    cut_set[5] = DIST_W'($urandom_range(1 << 16, 1 << 22));
    idle_set[0] = 0;  idle_set[1] = 60; idle_set[2] = 25;
    idle_set[3] = 0;  idle_set[4] = 60; idle_set[5] = 25;
    for (int ph = 0; ph < 6; ph++) begin
      set_cutoff(cut_set[ph]);
      sender_idle_pct = idle_set[ph];
      random_pairs(95);
    end
  endtask

  initial begin
    // Hold reset, then release it and run the tests in turn.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_cutoff();
    test_zero_cutoff();
    test_max_cutoff();
    test_random_traffic();
    drain_pipeline();
    $display("testbench: %0d pair requests sent under %0d cutoff writes plus the reset cutoff",
             pairs_sent, cutoffs_written);
    $display("testbench: %0d kept pairs compared, %0d faults", pairs_checked, fault_count);
    if (fault_count == 0 && kept_pairs_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
